@@ rtl/pxu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_pkg: shared types, codes and helpers for the pixel unpacker
// Holds the input kind codes, configuration register indexes, the divider
// lane type and the per-step divider and field extract functions.
// ----------------------------------------------------------------------------
package pxu_pkg;

    // Palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    // Channel lanes: red, green, blue, alpha
    localparam int LANES      = 4;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    // Divider stages, two quotient bits each
    localparam int DIV_STAGES = 4;

    // Widest field width in the packed word
    localparam logic [4:0] MAX_FIELD_W = 5'd16;

    // Input item kinds (s_tuser)
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_PALETTE_MODE = 3'd0;
    localparam logic [2:0] CFG_RED_BITS     = 3'd1;
    localparam logic [2:0] CFG_GREEN_BITS   = 3'd2;
    localparam logic [2:0] CFG_BLUE_BITS    = 3'd3;
    localparam logic [2:0] CFG_ALPHA_BITS   = 3'd4;

    // One channel in flight through the divider
    typedef struct packed {
        logic [23:0] rem;   // running remainder, starts as the dividend
        logic [15:0] dvs;   // divisor, never zero
        logic [7:0]  quo;   // quotient bits collected so far
    } lane_t;

    // First-stage payload: per-lane value, divisor and x255 select
    typedef struct packed {
        logic                    pal;
        logic [LANES-1:0]        scale;
        logic [LANES-1:0][15:0]  val;
        logic [LANES-1:0][15:0]  dvs;
    } s1_t;

    // Limit a configured field width to 16
    function automatic logic [4:0] clamp_w(logic [4:0] w);
        return (w > MAX_FIELD_W) ? MAX_FIELD_W : w;
    endfunction

    // All-ones mask of w bits, w in 0..16
    function automatic logic [15:0] field_mask(logic [4:0] w);
        return 16'((17'd1 << w) - 17'd1);
    endfunction

    // Field of width w at bit sh; bits above 15 read as zero
    function automatic logic [15:0] field_get(logic [15:0] word, logic [4:0] w,
                                              logic [5:0] sh);
        logic [15:0] f;
        if (sh >= 6'd16) begin
            f = '0;
        end else begin
            f = (word >> sh[3:0]) & field_mask(w);
        end
        return f;
    endfunction

    // One restoring division step for quotient bit sh
    function automatic lane_t div_step(lane_t l, logic [2:0] sh);
        lane_t       r;
        logic [23:0] sub;
        r   = l;
        sub = 24'(l.dvs) << sh;
        if (l.rem >= sub) begin
            r.rem     = l.rem - sub;
            r.quo[sh] = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/pxu_palette_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_palette_ram: palette memory
// One write port and one read port with registered read data. Entries hold
// {alpha, blue, green, red} as loaded; contents are unknown until written.
// ----------------------------------------------------------------------------
module pxu_palette_ram (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [pxu_pkg::PAL_AW-1:0] wr_addr,
    input  wire logic [31:0]               wr_data,
    input  wire logic                      rd_en,
    input  wire logic [pxu_pkg::PAL_AW-1:0] rd_addr,
    output      logic [31:0]               rd_data
);

    logic [31:0] mem [pxu_pkg::PAL_ENTRIES];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/pxu_scale_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_scale_pipe: pipelined 24/16 divider, four channel lanes
// Each stage resolves two quotient bits by restoring division. Valid bits
// travel with the data and a per-stage ready chain lets bubbles collapse.
// ----------------------------------------------------------------------------
module pxu_scale_pipe (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire pxu_pkg::lane_t [pxu_pkg::LANES-1:0]  in_lanes,
    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      logic [31:0]                          out_data   // red, green, blue, alpha
);

    localparam int NS = pxu_pkg::DIV_STAGES;

    logic [NS-1:0]                        valid_reg;
    pxu_pkg::lane_t [pxu_pkg::LANES-1:0]  lane_reg [NS];
    logic [NS:0]                          ready;

    assign ready[NS] = out_ready;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        pxu_pkg::lane_t [pxu_pkg::LANES-1:0] src;
        pxu_pkg::lane_t [pxu_pkg::LANES-1:0] lane_next;
        logic                                vin;

        if (k == 0) begin : g_first
            assign src = in_lanes;
            assign vin = in_valid;
        end else begin : g_rest
            assign src = lane_reg[k-1];
            assign vin = valid_reg[k-1];
        end

        assign ready[k] = !valid_reg[k] || ready[k+1];

        // Two quotient bits per stage, high bits first
        always_comb begin
            for (int l = 0; l < pxu_pkg::LANES; l++) begin
                lane_next[l] = pxu_pkg::div_step(
                    pxu_pkg::div_step(src[l], 3'(7 - 2 * k)), 3'(6 - 2 * k));
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ready[k]) begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (ready[k] && vin) begin
                lane_reg[k] <= lane_next;
            end
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[NS-1];

    always_comb begin
        for (int l = 0; l < pxu_pkg::LANES; l++) begin
            out_data[l*8 +: 8] = lane_reg[NS-1][l].quo;
        end
    end

endmodule
`default_nettype wire

@@ rtl/pixel_unpack_to_rgba8_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_unpack_to_rgba8_top: pixel unpacker to RGBA8
// Converts palette-indexed or packed bitfield pixels to four bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item per handshake. s_tuser = 0 loads a palette
//   entry (no result), s_tuser = 1 converts one pixel (one result on m_).
//   Load an entry before any pixel reads it.
//   cfg_wr_en/cfg_addr/cfg_wr_data write the mode and field widths; write
//   them only while no pixel is in flight.
//   Throughput: one item per cycle while m_tready lets the pipeline move.
//   The stages are field extract with palette read, palette swap or x255
//   scaling, then four divider stages of two quotient bits each; every
//   channel has its own divider lane.
//   Reset clears the configuration to packed mode, widths 5/5/5 with 1-bit
//   alpha, and empties the pipeline. The palette is not cleared.
//   When m_tready is low the pipeline fills its empty stages and then
//   holds s_tready low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pixel_unpack_to_rgba8_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [55:0] s_tdata,   // palette_index, entry_red, entry_green,
                                        // entry_blue, entry_alpha, pixel_word
    input  wire logic        s_tuser,   // operation
    // result item
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [4:0]  cfg_wr_data
);

    // Configuration registers
    logic       palette_mode_reg;
    logic [4:0] red_bits_reg;
    logic [4:0] green_bits_reg;
    logic [4:0] blue_bits_reg;
    logic [4:0] alpha_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_mode_reg <= 1'b0;
            red_bits_reg     <= 5'd5;
            green_bits_reg   <= 5'd5;
            blue_bits_reg    <= 5'd5;
            alpha_bits_reg   <= 5'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pxu_pkg::CFG_PALETTE_MODE: palette_mode_reg <= cfg_wr_data[0];
                pxu_pkg::CFG_RED_BITS:     red_bits_reg     <= cfg_wr_data;
                pxu_pkg::CFG_GREEN_BITS:   green_bits_reg   <= cfg_wr_data;
                pxu_pkg::CFG_BLUE_BITS:    blue_bits_reg    <= cfg_wr_data;
                pxu_pkg::CFG_ALPHA_BITS:   alpha_bits_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input fields
    logic [7:0]  in_index;
    logic [31:0] in_entry;
    logic [15:0] in_word;

    assign in_index = s_tdata[7:0];
    assign in_entry = s_tdata[39:8];    // {alpha, blue, green, red}
    assign in_word  = s_tdata[55:40];

    // Handshake chain
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic pipe_in_ready;
    logic rdy1;
    logic rdy2;
    logic accept;

    assign rdy2     = !s2_valid_reg || pipe_in_ready;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    // Palette memory: loads write, pixels read
    logic [31:0] pal_rdata;

    pxu_palette_ram u_pal (
        .aclk    (aclk),
        .wr_en   (accept && (s_tuser == pxu_pkg::OP_LOAD)),
        .wr_addr (in_index[pxu_pkg::PAL_AW-1:0]),
        .wr_data (in_entry),
        .rd_en   (accept && (s_tuser == pxu_pkg::OP_PIXEL)),
        .rd_addr (in_index[pxu_pkg::PAL_AW-1:0]),
        .rd_data (pal_rdata)
    );

    // Stage 1: field widths, shifts and extraction
    logic [4:0]      rw;
    logic [4:0]      gw;
    logic [4:0]      bw;
    logic [4:0]      aw;
    logic [5:0]      sh_g;
    logic [5:0]      sh_r;
    logic [5:0]      sh_a;
    pxu_pkg::s1_t    s1_next;
    pxu_pkg::s1_t    s1_reg;

    always_comb begin
        rw   = pxu_pkg::clamp_w(red_bits_reg);
        gw   = pxu_pkg::clamp_w(green_bits_reg);
        bw   = pxu_pkg::clamp_w(blue_bits_reg);
        aw   = pxu_pkg::clamp_w(alpha_bits_reg);
        sh_g = 6'(bw);
        sh_r = 6'(bw) + 6'(gw);
        sh_a = sh_r + 6'(rw);

        s1_next.pal = palette_mode_reg;
        // zero width: constant lane, value/1
        s1_next.val[pxu_pkg::LANE_RED]     = pxu_pkg::field_get(in_word, rw, sh_r);
        s1_next.val[pxu_pkg::LANE_GREEN]   = pxu_pkg::field_get(in_word, gw, sh_g);
        s1_next.val[pxu_pkg::LANE_BLUE]    = pxu_pkg::field_get(in_word, bw, 6'd0);
        s1_next.val[pxu_pkg::LANE_ALPHA]   = (aw == 5'd0) ? 16'd255
                                           : pxu_pkg::field_get(in_word, aw, sh_a);
        s1_next.dvs[pxu_pkg::LANE_RED]     = (rw == 5'd0) ? 16'd1 : pxu_pkg::field_mask(rw);
        s1_next.dvs[pxu_pkg::LANE_GREEN]   = (gw == 5'd0) ? 16'd1 : pxu_pkg::field_mask(gw);
        s1_next.dvs[pxu_pkg::LANE_BLUE]    = (bw == 5'd0) ? 16'd1 : pxu_pkg::field_mask(bw);
        s1_next.dvs[pxu_pkg::LANE_ALPHA]   = (aw == 5'd0) ? 16'd1 : pxu_pkg::field_mask(aw);
        s1_next.scale[pxu_pkg::LANE_RED]   = (rw != 5'd0);
        s1_next.scale[pxu_pkg::LANE_GREEN] = (gw != 5'd0);
        s1_next.scale[pxu_pkg::LANE_BLUE]  = (bw != 5'd0);
        s1_next.scale[pxu_pkg::LANE_ALPHA] = (aw != 5'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (rdy1) begin
            s1_valid_reg <= s_tvalid && (s_tuser == pxu_pkg::OP_PIXEL);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: palette swap or x255 scaling into divider lanes
    logic [7:0]                                   pal_byte [pxu_pkg::LANES];
    pxu_pkg::lane_t [pxu_pkg::LANES-1:0]          s2_next;
    pxu_pkg::lane_t [pxu_pkg::LANES-1:0]          s2_reg;

    always_comb begin
        // red and blue swapped; alpha set where the stored alpha is zero
        pal_byte[pxu_pkg::LANE_RED]   = pal_rdata[23:16];
        pal_byte[pxu_pkg::LANE_GREEN] = pal_rdata[15:8];
        pal_byte[pxu_pkg::LANE_BLUE]  = pal_rdata[7:0];
        pal_byte[pxu_pkg::LANE_ALPHA] = (pal_rdata[31:24] == 8'd0) ? 8'd255 : 8'd0;

        for (int l = 0; l < pxu_pkg::LANES; l++) begin
            s2_next[l].quo = '0;
            if (s1_reg.pal) begin
                s2_next[l].rem = 24'(pal_byte[l]);
                s2_next[l].dvs = 16'd1;
            end else begin
                s2_next[l].dvs = s1_reg.dvs[l];
                if (s1_reg.scale[l]) begin
                    s2_next[l].rem = (24'(s1_reg.val[l]) << 8) - 24'(s1_reg.val[l]);
                end else begin
                    s2_next[l].rem = 24'(s1_reg.val[l]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    // Stages 3 to 6: divide by the field mask
    pxu_scale_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_ready  (pipe_in_ready),
        .in_lanes  (s2_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire

@@ tb/pixel_unpack_to_rgba8_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_unpack_to_rgba8_top_tb: self-checking bench for the RGBA8 unpacker
// Drives palette loads and pixel items on the input stream, predicts each
// RGBA8 result from a shadow palette and shadow format registers, and checks
// every result in order. Covers reset format, width extremes, palette
// lookups, random formats under sender and receiver idling, and a long
// output stall.
// ----------------------------------------------------------------------------
module pixel_unpack_to_rgba8_top_tb;

    // Four channel bytes, red in the lowest bits (matches m_tdata)
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    // One input item, laid out as s_tdata
    typedef struct packed {
        logic [15:0] word;
        rgba_t       entry;
        logic [7:0]  idx;
    } pix_item_t;

    // DUT signals
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_addr    = '0;
    logic [4:0]  cfg_wr_data = '0;

    // Shadow format registers, reset values
    logic       fmt_palette = 1'b0;
    logic [4:0] w_red       = 5'd5;
    logic [4:0] w_green     = 5'd5;
    logic [4:0] w_blue      = 5'd5;
    logic [4:0] w_alpha     = 5'd1;

    // Shadow palette; only loaded entries are ever read
    rgba_t      pal_shadow [256];
    bit         pal_loaded [256];
    logic [7:0] loaded_idx_q [$];

    // Results still owed by the block, oldest first
    rgba_t      pending_rgba_q [$];

    // Idling knobs and counters
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int unsigned hold_off     = 0;
    int          fail_count   = 0;
    int          loads_sent   = 0;
    int          pixels_sent  = 0;
    int          results_seen = 0;
    int          reg_writes   = 0;
    rgba_t       got_px;
    rgba_t       want_px;

    pixel_unpack_to_rgba8_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Widths above 16 behave as 16
    function automatic int unsigned clip16(logic [4:0] w);
        return (w > 5'd16) ? 16 : int'(w);
    endfunction

    // Field of w bits at lsb, scaled to 0..255 and rounded down
    function automatic logic [7:0] field_to_byte(logic [15:0] word, int unsigned w,
                                                 int unsigned lsb);
        longint unsigned ones;
        longint unsigned val;
        if (w == 0) begin
            return 8'd0;
        end
        ones = (64'd1 << w) - 64'd1;
        // bits above 15 read as zero
        val = (lsb >= 16) ? 64'd0 : ((64'(word) >> lsb) & ones);
        return 8'((val * 64'd255) / ones);
    endfunction

    // RGBA8 that a pixel item turns into under the current format
    function automatic rgba_t predict_rgba(logic [7:0] idx, logic [15:0] word);
        rgba_t       px;
        rgba_t       e;
        int unsigned rb, gb, bb, ab;
        if (fmt_palette) begin
            // red and blue swap; alpha is inverted to opaque/transparent
            e        = pal_shadow[idx];
            px.red   = e.blue;
            px.green = e.green;
            px.blue  = e.red;
            px.alpha = (e.alpha == 8'd0) ? 8'hFF : 8'h00;
        end else begin
            rb       = clip16(w_red);
            gb       = clip16(w_green);
            bb       = clip16(w_blue);
            ab       = clip16(w_alpha);
            px.blue  = field_to_byte(word, bb, 0);
            px.green = field_to_byte(word, gb, bb);
            px.red   = field_to_byte(word, rb, gb + bb);
            px.alpha = (ab == 0) ? 8'hFF : field_to_byte(word, ab, rb + gb + bb);
        end
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        $display("MISMATCH t=%0t result #%0d %s: got %0d, want %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Compare each accepted result with the oldest pending one
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_rgba_q.size() == 0) begin
                report_mismatch("result with no pixel pending", 8'd0, 8'd0);
            end else begin
                want_px = pending_rgba_q.pop_front();
                got_px  = m_tdata;
                if (got_px.red != want_px.red)
                    report_mismatch("red", got_px.red, want_px.red);
                if (got_px.green != want_px.green)
                    report_mismatch("green", got_px.green, want_px.green);
                if (got_px.blue != want_px.blue)
                    report_mismatch("blue", got_px.blue, want_px.blue);
                if (got_px.alpha != want_px.alpha)
                    report_mismatch("alpha", got_px.alpha, want_px.alpha);
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout: block stopped making progress");
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item, wait for the handshake, then update the shadow state
    task automatic send_item(input logic op, input pix_item_t it);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        if (op == pxu_pkg::OP_LOAD) begin
            loads_sent++;
            pal_shadow[it.idx] = it.entry;
            if (!pal_loaded[it.idx]) begin
                pal_loaded[it.idx] = 1'b1;
                loaded_idx_q.push_back(it.idx);
            end
        end else begin
            pixels_sent++;
            pending_rgba_q.push_back(predict_rgba(it.idx, it.word));
        end
    endtask

    // Load with a random (ignored) pixel word
    task automatic send_load(input logic [7:0] idx, input rgba_t entry);
        pix_item_t it;
        it.idx   = idx;
        it.entry = entry;
        it.word  = 16'($urandom);
        send_item(pxu_pkg::OP_LOAD, it);
    endtask

    // Pixel with random (ignored) entry bytes
    task automatic send_pixel(input logic [7:0] idx, input logic [15:0] word);
        pix_item_t it;
        it.idx   = idx;
        it.entry = rgba_t'($urandom);
        it.word  = word;
        send_item(pxu_pkg::OP_PIXEL, it);
    endtask

    // Stop offering and let everything in flight come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_rgba_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // One register write at the next edge; caller drops the enable
    task automatic write_reg(input logic [2:0] addr, input logic [4:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        reg_writes++;
        case (addr)
            pxu_pkg::CFG_PALETTE_MODE: fmt_palette = data[0];
            pxu_pkg::CFG_RED_BITS:     w_red       = data;
            pxu_pkg::CFG_GREEN_BITS:   w_green     = data;
            pxu_pkg::CFG_BLUE_BITS:    w_blue      = data;
            pxu_pkg::CFG_ALPHA_BITS:   w_alpha     = data;
            default: ;
        endcase
    endtask

    // Program the whole format once the block is idle
    task automatic set_format(input logic mode, input logic [4:0] rb, input logic [4:0] gb,
                              input logic [4:0] bb, input logic [4:0] ab);
        wait_idle();
        // upper bits of the mode write are don't-care
        write_reg(pxu_pkg::CFG_PALETTE_MODE, {4'($urandom), mode});
        write_reg(pxu_pkg::CFG_RED_BITS, rb);
        write_reg(pxu_pkg::CFG_GREEN_BITS, gb);
        write_reg(pxu_pkg::CFG_BLUE_BITS, bb);
        write_reg(pxu_pkg::CFG_ALPHA_BITS, ab);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly narrow widths, with zero, full and over-range ones mixed in
    function automatic logic [4:0] pick_width();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 5'd0;
        if (r == 1) return 5'd16;
        if (r == 2) return 5'($urandom_range(31, 17));
        return 5'($urandom_range(8, 1));
    endfunction

    // Idling mixes: none, sender gaps, receiver stalls, both
    task automatic set_idling(input int ph);
        case (ph)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 49; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 49; end
            default: begin send_gap_pct = 31; stall_pct = 31; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Packed pixels under the reset format (5/5/5 with 1-bit alpha)
    task automatic test_reset_format();
        send_pixel(8'h00, 16'h0000);
        send_pixel(8'hFF, 16'hFFFF);
        send_pixel(8'h5A, 16'h8000);
        send_pixel(8'hA5, 16'h7C1F);
    endtask

    // Width extremes, clamping, fields past bit 15, writes past the register list
    task automatic test_format_extremes();
        set_format(1'b0, 5'd16, 5'd0, 5'd0, 5'd0);
        send_pixel(8'h00, 16'hFFFF);
        send_pixel(8'h00, 16'h0001);
        set_format(1'b0, 5'd0, 5'd0, 5'd0, 5'd0);
        send_pixel(8'h00, 16'($urandom));
        set_format(1'b0, 5'd31, 5'd31, 5'd31, 5'd31);
        send_pixel(8'h00, 16'hFFFF);
        send_pixel(8'h00, 16'h1234);
        set_format(1'b0, 5'd8, 5'd4, 5'd4, 5'd16);
        send_pixel(8'h00, 16'hFFFF);
        set_format(1'b0, 5'd1, 5'd1, 5'd1, 5'd1);
        send_pixel(8'h00, 16'h000F);
        send_pixel(8'h00, 16'h0005);
        // addresses past the list must leave the format alone
        wait_idle();
        write_reg(3'd5, 5'h1F);
        write_reg(3'd6, 5'h00);
        write_reg(3'd7, 5'h10);
        cfg_wr_en <= 1'b0;
        send_pixel(8'h00, 16'hFFFF);
    endtask

    // Palette lookups: extreme entries, alpha both ways, load then read at once
    task automatic test_palette_directed();
        set_format(1'b1, 5'd5, 5'd5, 5'd5, 5'd1);
        send_load(8'h00, '0);
        send_load(8'hFF, '1);
        send_load(8'h55, '{alpha: 8'h00, blue: 8'h0F, green: 8'hAA, red: 8'hF0});
        send_pixel(8'h00, 16'hFFFF);
        send_pixel(8'hFF, 16'h0000);
        send_pixel(8'h55, 16'($urandom));
        send_load(8'hAA, '{alpha: 8'h00, blue: 8'h12, green: 8'h34, red: 8'h56});
        send_pixel(8'hAA, 16'($urandom));
        send_load(8'hAA, '{alpha: 8'h01, blue: 8'h9A, green: 8'hBC, red: 8'hDE});
        send_pixel(8'hAA, 16'($urandom));
    endtask

    // Random packed formats; a few loads mixed in that must give no result
    task automatic test_random_packed();
        logic [15:0] word;
        for (int ph = 0; ph < 4; ph++) begin
            set_idling(ph);
            for (int f = 0; f < 4; f++) begin
                set_format(1'b0, pick_width(), pick_width(), pick_width(), pick_width());
                for (int n = 0; n < 50; n++) begin
                    if ($urandom_range(99) < 15) begin
                        send_load(8'($urandom), rgba_t'($urandom));
                    end else begin
                        word = 16'($urandom);
                        if ($urandom_range(15) == 0) word = $urandom_range(1) ? '1 : '0;
                        send_pixel(8'($urandom), word);
                    end
                end
            end
        end
    endtask

    // Random palette traffic: loads anywhere, pixels only from loaded entries
    task automatic test_random_palette();
        for (int ph = 0; ph < 4; ph++) begin
            set_idling(ph);
            set_format(1'b1, pick_width(), pick_width(), pick_width(), pick_width());
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(99) < 30) begin
                    send_load(8'($urandom), rgba_t'($urandom));
                end else begin
                    send_pixel(loaded_idx_q[$urandom_range(loaded_idx_q.size() - 1)],
                               16'($urandom));
                end
            end
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_output_backpressure();
        set_idling(0);
        set_format(1'b0, pick_width(), pick_width(), pick_width(), pick_width());
        hold_off = 200;
        for (int n = 0; n < 60; n++) begin
            send_pixel(8'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_format();
        test_format_extremes();
        test_palette_directed();
        test_random_packed();
        test_random_palette();
        test_output_backpressure();
        wait_idle();

        $display("Covered %0d palette loads and %0d pixels, %0d results checked,",
                 loads_sent, pixels_sent, results_seen);
        $display("%0d register writes over four idling mixes and one long output hold-off.",
                 reg_writes);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
